@@ sv/ltps_pkg.sv @@
package ltps_pkg;

    // field widths
    localparam int EVENT_W   = 2;
    localparam int POS_W     = 22;
    localparam int COORD_W   = 23;
    localparam int KIND_W    = 3;
    localparam int FEED_W    = 14;
    localparam int SPIN_W    = 2;
    localparam int RPM_W     = 16;
    localparam int DIAM_W    = 21;
    localparam int DEPTH_W   = 17;
    localparam int PASS_W    = 16;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 21;

    // event codes
    localparam logic [EVENT_W-1:0] EV_START = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DONE  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ERROR = 2'd2;

    // move codes
    localparam logic [KIND_W-1:0] MV_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] MV_SYNC    = 3'd1;
    localparam logic [KIND_W-1:0] MV_RAPID_X = 3'd2;
    localparam logic [KIND_W-1:0] MV_FEED_Z  = 3'd3;
    localparam logic [KIND_W-1:0] MV_RAPID_Z = 3'd4;

    // spindle commands
    localparam logic [SPIN_W-1:0] SP_NONE  = 2'd0;
    localparam logic [SPIN_W-1:0] SP_START = 2'd1;
    localparam logic [SPIN_W-1:0] SP_STOP  = 2'd2;

    // cycle phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PLAN    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FEED    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RETRACT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RETURN  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_STOP    = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_DIAMETER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUGH_DEPTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_DEPTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_LENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRACT_DIST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUGH_FEED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_FEED    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPINDLE_RPM    = 3'd7;

    // register reset values
    localparam logic [DIAM_W-1:0]  RST_DELTA_DIAMETER = 21'h1FFC18;   // -1000
    localparam logic [DEPTH_W-1:0] RST_ROUGH_DEPTH    = 17'd200;
    localparam logic [DEPTH_W-1:0] RST_FINISH_DEPTH   = 17'd100;
    localparam logic [DIAM_W-1:0]  RST_CUT_LENGTH     = 21'h1FD8F0;   // -10000
    localparam logic [DEPTH_W-1:0] RST_RETRACT_DIST   = 17'd100;
    localparam logic [FEED_W-1:0]  RST_ROUGH_FEED     = 14'd200;
    localparam logic [FEED_W-1:0]  RST_FINISH_FEED    = 14'd80;
    localparam logic [RPM_W-1:0]   RST_SPINDLE_RPM    = 16'd1000;

endpackage

@@ sv/lathe_turning_pass_sequencer_unit.sv @@
// Multi-pass turning cycle sequencer working in integer micrometres. Every event
// transfer produces exactly one command transfer. The unit takes one event per
// clock cycle while the output is not stalled, passing it through the event
// register, then the command register; a stalled output holds one command while a
// further event waits in the event register. The longest path is the pass
// planner: a 16x17 multiply of pass count by rough depth, saturation, and the
// add that places the X target. cfg_ready is always high; write registers only
// while no cycle is running and no event or command is still in flight.
// Registers are read live except the cut direction and the rough feed, which are latched at start.
module lathe_turning_pass_sequencer_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ltps_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ltps_pkg::CFG_DAT_W-1:0]          cfg_data,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [ltps_pkg::EVENT_W-1:0]            event_kind,
    input  logic                                    executor_ready,
    input  logic                                    spindle_running,
    input  logic signed [ltps_pkg::POS_W-1:0]       pos_x,
    input  logic signed [ltps_pkg::POS_W-1:0]       pos_z,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [ltps_pkg::KIND_W-1:0]             move_kind,
    output logic signed [ltps_pkg::COORD_W-1:0]     move_target,
    output logic [ltps_pkg::FEED_W-1:0]             move_feed,
    output logic [ltps_pkg::SPIN_W-1:0]             spindle_cmd,
    output logic [ltps_pkg::RPM_W-1:0]              speed_request,
    output logic                                    cycle_busy
);

    localparam int PROD_W = ltps_pkg::PASS_W + ltps_pkg::DEPTH_W;

    // configuration registers
    logic [ltps_pkg::DIAM_W-1:0]   delta_diameter_reg;
    logic [ltps_pkg::DEPTH_W-1:0]  rough_depth_reg;
    logic [ltps_pkg::DEPTH_W-1:0]  finish_depth_reg;
    logic [ltps_pkg::DIAM_W-1:0]   cut_length_reg;
    logic [ltps_pkg::DEPTH_W-1:0]  retract_dist_reg;
    logic [ltps_pkg::FEED_W-1:0]   rough_feed_reg;
    logic [ltps_pkg::FEED_W-1:0]   finish_feed_reg;
    logic [ltps_pkg::RPM_W-1:0]    spindle_rpm_reg;

    // event register
    logic                          s1_valid_reg;
    logic [ltps_pkg::EVENT_W-1:0]  ev_reg;
    logic                          ready_reg;
    logic                          running_reg;
    logic [ltps_pkg::POS_W-1:0]    pos_x_reg;
    logic [ltps_pkg::POS_W-1:0]    pos_z_reg;

    // cycle state
    logic [ltps_pkg::PHASE_W-1:0]  phase_reg,       phase_next;
    logic                          dir_neg_reg,     dir_neg_next;
    logic [ltps_pkg::COORD_W-1:0]  target_x_reg,    target_x_next;
    logic [ltps_pkg::COORD_W-1:0]  start_x_reg,     start_x_next;
    logic [ltps_pkg::COORD_W-1:0]  start_z_reg,     start_z_next;
    logic [ltps_pkg::DIAM_W-1:0]   cut_depth_reg,   cut_depth_next;
    logic [ltps_pkg::PASS_W-1:0]   pass_count_reg,  pass_count_next;
    logic [ltps_pkg::FEED_W-1:0]   active_feed_reg, active_feed_next;

    // command register
    logic                          out_valid_reg;
    logic [ltps_pkg::KIND_W-1:0]   kind_reg,        kind_next;
    logic [ltps_pkg::COORD_W-1:0]  tgt_reg,         tgt_next;
    logic [ltps_pkg::FEED_W-1:0]   feed_reg,        feed_next;
    logic [ltps_pkg::SPIN_W-1:0]   spin_reg,        spin_next;
    logic [ltps_pkg::RPM_W-1:0]    speed_reg,       speed_next;
    logic                          busy_reg;

    logic                          advance;
    logic                          s1_fire;

    // planner datapath
    logic [ltps_pkg::POS_W-1:0]    delta_ext;
    logic [ltps_pkg::POS_W-1:0]    full_abs;
    logic [ltps_pkg::COORD_W-1:0]  diff;
    logic [ltps_pkg::DEPTH_W:0]    rough_plus_finish;
    logic [ltps_pkg::DEPTH_W:0]    finish_plus_one;
    logic [PROD_W-1:0]             prod;
    logic [ltps_pkg::DIAM_W-1:0]   prod_sat;
    logic [ltps_pkg::POS_W-1:0]    semi_depth;
    logic [ltps_pkg::DIAM_W-1:0]   plan_depth;
    logic [ltps_pkg::DIAM_W:0]     depth_round;
    logic [ltps_pkg::COORD_W-1:0]  x_offset;
    logic [ltps_pkg::COORD_W-1:0]  plan_target;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign s1_fire   = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_diameter_reg <= ltps_pkg::RST_DELTA_DIAMETER;
            rough_depth_reg    <= ltps_pkg::RST_ROUGH_DEPTH;
            finish_depth_reg   <= ltps_pkg::RST_FINISH_DEPTH;
            cut_length_reg     <= ltps_pkg::RST_CUT_LENGTH;
            retract_dist_reg   <= ltps_pkg::RST_RETRACT_DIST;
            rough_feed_reg     <= ltps_pkg::RST_ROUGH_FEED;
            finish_feed_reg    <= ltps_pkg::RST_FINISH_FEED;
            spindle_rpm_reg    <= ltps_pkg::RST_SPINDLE_RPM;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ltps_pkg::CFG_DELTA_DIAMETER:
                    delta_diameter_reg <= cfg_data[ltps_pkg::DIAM_W-1:0];
                ltps_pkg::CFG_ROUGH_DEPTH:
                    rough_depth_reg    <= cfg_data[ltps_pkg::DEPTH_W-1:0];
                ltps_pkg::CFG_FINISH_DEPTH:
                    finish_depth_reg   <= cfg_data[ltps_pkg::DEPTH_W-1:0];
                ltps_pkg::CFG_CUT_LENGTH:
                    cut_length_reg     <= cfg_data[ltps_pkg::DIAM_W-1:0];
                ltps_pkg::CFG_RETRACT_DIST:
                    retract_dist_reg   <= cfg_data[ltps_pkg::DEPTH_W-1:0];
                ltps_pkg::CFG_ROUGH_FEED:
                    rough_feed_reg     <= cfg_data[ltps_pkg::FEED_W-1:0];
                ltps_pkg::CFG_FINISH_FEED:
                    finish_feed_reg    <= cfg_data[ltps_pkg::FEED_W-1:0];
                default:
                    spindle_rpm_reg    <= cfg_data[ltps_pkg::RPM_W-1:0];
            endcase
        end
    end

    // event register: load on an input transfer, drop once consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_reg      <= event_kind;
            ready_reg   <= executor_ready;
            running_reg <= spindle_running;
            pos_x_reg   <= pos_x;
            pos_z_reg   <= pos_z;
        end
    end

    // pass planner
    always_comb
    begin
        delta_ext         = {delta_diameter_reg[ltps_pkg::DIAM_W-1], delta_diameter_reg};
        full_abs          = delta_diameter_reg[ltps_pkg::DIAM_W-1] ? (~delta_ext + 1'b1)
                                                                   : delta_ext;
        diff              = {1'b0, full_abs} - {2'b00, cut_depth_reg};
        rough_plus_finish = {1'b0, rough_depth_reg} + {1'b0, finish_depth_reg};
        finish_plus_one   = {1'b0, finish_depth_reg} + 1'b1;
        prod              = {{ltps_pkg::DEPTH_W{1'b0}}, pass_count_reg}
                          * {{ltps_pkg::PASS_W{1'b0}}, rough_depth_reg};
        prod_sat          = (|prod[PROD_W-1:ltps_pkg::DIAM_W]) ? {ltps_pkg::DIAM_W{1'b1}}
                                                              : prod[ltps_pkg::DIAM_W-1:0];
        semi_depth        = full_abs - {{(ltps_pkg::POS_W-ltps_pkg::DEPTH_W){1'b0}},
                                        finish_depth_reg};

        priority if ($signed(diff) >= $signed({5'b0, rough_plus_finish}))
        begin
            plan_depth = prod_sat;
        end
        else if ($signed(diff) <= $signed({5'b0, finish_plus_one}))
        begin
            plan_depth = full_abs[ltps_pkg::DIAM_W-1:0];
        end
        else
        begin
            plan_depth = semi_depth[ltps_pkg::DIAM_W-1:0];
        end

        // half the diameter step, rounded away from the start position
        depth_round = {1'b0, plan_depth} + 1'b1;
        x_offset    = {2'b00, depth_round[ltps_pkg::DIAM_W:1]};
        plan_target = dir_neg_reg ? (start_x_reg - x_offset) : (start_x_reg + x_offset);
    end

    // sequencer
    always_comb
    begin
        phase_next       = phase_reg;
        dir_neg_next     = dir_neg_reg;
        target_x_next    = target_x_reg;
        start_x_next     = start_x_reg;
        start_z_next     = start_z_reg;
        cut_depth_next   = cut_depth_reg;
        pass_count_next  = pass_count_reg;
        active_feed_next = active_feed_reg;
        kind_next        = ltps_pkg::MV_NONE;
        tgt_next         = '0;
        feed_next        = '0;
        spin_next        = ltps_pkg::SP_NONE;
        speed_next       = '0;

        if (ev_reg == ltps_pkg::EV_ERROR)
        begin
            phase_next = ltps_pkg::PH_IDLE;
        end
        else if (phase_reg == ltps_pkg::PH_IDLE)
        begin
            if (ev_reg == ltps_pkg::EV_START && ready_reg)
            begin
                dir_neg_next     = delta_diameter_reg[ltps_pkg::DIAM_W-1];
                start_x_next     = {pos_x_reg[ltps_pkg::POS_W-1], pos_x_reg};
                start_z_next     = {pos_z_reg[ltps_pkg::POS_W-1], pos_z_reg};
                target_x_next    = {pos_x_reg[ltps_pkg::POS_W-1], pos_x_reg};
                cut_depth_next   = '0;
                pass_count_next  = {{(ltps_pkg::PASS_W-1){1'b0}}, 1'b1};
                active_feed_next = rough_feed_reg;
                phase_next       = ltps_pkg::PH_PLAN;
                kind_next        = ltps_pkg::MV_SYNC;
                speed_next       = spindle_rpm_reg;
                if (!running_reg)
                begin
                    spin_next = ltps_pkg::SP_START;
                end
            end
        end
        else if (ev_reg == ltps_pkg::EV_DONE)
        begin
            unique case (phase_reg)
                ltps_pkg::PH_PLAN:
                begin
                    kind_next = ltps_pkg::MV_RAPID_X;
                    if (diff == '0)
                    begin
                        // full depth reached: rapid X back to the last cut target, then stop
                        phase_next = ltps_pkg::PH_STOP;
                        tgt_next   = target_x_reg;
                    end
                    else
                    begin
                        if ($signed(diff) >= $signed({5'b0, rough_plus_finish}))
                        begin
                            pass_count_next = pass_count_reg + 1'b1;
                        end
                        else if ($signed(diff) <= $signed({5'b0, finish_plus_one}))
                        begin
                            active_feed_next = finish_feed_reg;
                        end
                        cut_depth_next = plan_depth;
                        target_x_next  = plan_target;
                        phase_next     = ltps_pkg::PH_FEED;
                        tgt_next       = plan_target;
                    end
                end
                ltps_pkg::PH_FEED:
                begin
                    kind_next  = ltps_pkg::MV_FEED_Z;
                    tgt_next   = start_z_reg + {{2{cut_length_reg[ltps_pkg::DIAM_W-1]}},
                                                cut_length_reg};
                    feed_next  = active_feed_reg;
                    phase_next = ltps_pkg::PH_RETRACT;
                end
                ltps_pkg::PH_RETRACT:
                begin
                    kind_next  = ltps_pkg::MV_RAPID_X;
                    tgt_next   = dir_neg_reg
                               ? target_x_reg + {6'b0, retract_dist_reg}
                               : target_x_reg - {6'b0, retract_dist_reg};
                    phase_next = ltps_pkg::PH_RETURN;
                end
                ltps_pkg::PH_RETURN:
                begin
                    kind_next  = ltps_pkg::MV_RAPID_Z;
                    tgt_next   = start_z_reg;
                    phase_next = ltps_pkg::PH_PLAN;
                end
                default:
                begin
                    phase_next = ltps_pkg::PH_IDLE;
                    if (running_reg)
                    begin
                        spin_next = ltps_pkg::SP_STOP;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ltps_pkg::PH_IDLE;
            dir_neg_reg     <= 1'b0;
            target_x_reg    <= '0;
            start_x_reg     <= '0;
            start_z_reg     <= '0;
            cut_depth_reg   <= '0;
            pass_count_reg  <= '0;
            active_feed_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                phase_reg       <= phase_next;
                dir_neg_reg     <= dir_neg_next;
                target_x_reg    <= target_x_next;
                start_x_reg     <= start_x_next;
                start_z_reg     <= start_z_next;
                cut_depth_reg   <= cut_depth_next;
                pass_count_reg  <= pass_count_next;
                active_feed_reg <= active_feed_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            kind_reg  <= kind_next;
            tgt_reg   <= tgt_next;
            feed_reg  <= feed_next;
            spin_reg  <= spin_next;
            speed_reg <= speed_next;
            busy_reg  <= (phase_next != ltps_pkg::PH_IDLE);
        end
    end

    assign out_valid     = out_valid_reg;
    assign move_kind     = kind_reg;
    assign move_target   = tgt_reg;
    assign move_feed     = feed_reg;
    assign spindle_cmd   = spin_reg;
    assign speed_request = speed_reg;
    assign cycle_busy    = busy_reg;

    // a consumed event always leaves a command behind
    a_event_to_command: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("event consumed without a command");

    // busy flag of the newest command matches the live phase
    a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (busy_reg == (phase_reg != ltps_pkg::PH_IDLE)))
        else $error("cycle_busy out of step with phase");

    // feed only travels with a feed move
    a_feed_only_on_feed_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == ltps_pkg::MV_FEED_Z || feed_reg == '0))
        else $error("feed on a non-feed move");

    // a speed request only comes with the sync of an accepted start
    a_speed_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && speed_reg != '0) |-> (kind_reg == ltps_pkg::MV_SYNC && busy_reg))
        else $error("speed request outside a cycle start");

endmodule

@@ tb/tb_lathe_turning_pass_sequencer_unit.sv @@
`timescale 1ns / 1ps

module tb_lathe_turning_pass_sequencer_unit;

    // event code that the unit must ignore in every phase
    localparam logic [ltps_pkg::EVENT_W-1:0] EV_UNUSED = 2'd3;

    typedef struct packed {
        logic [ltps_pkg::EVENT_W-1:0] kind;
        logic                         exec_rdy;
        logic                         spin_run;
        logic [ltps_pkg::POS_W-1:0]   pos_x;
        logic [ltps_pkg::POS_W-1:0]   pos_z;
    } turn_event_t;

    typedef struct packed {
        logic [ltps_pkg::KIND_W-1:0]  move_kind;
        logic [ltps_pkg::COORD_W-1:0] move_target;
        logic [ltps_pkg::FEED_W-1:0]  move_feed;
        logic [ltps_pkg::SPIN_W-1:0]  spindle_cmd;
        logic [ltps_pkg::RPM_W-1:0]   speed_request;
        logic                         cycle_busy;
    } move_cmd_t;

    typedef struct {
        int delta;
        int rough;
        int finish;
        int length;
        int retract;
        int rfeed;
        int ffeed;
        int rpm;
    } cut_setup_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [ltps_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [ltps_pkg::CFG_DAT_W-1:0]      cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [ltps_pkg::EVENT_W-1:0]        event_kind = '0;
    logic                                executor_ready = 1'b0;
    logic                                spindle_running = 1'b0;
    logic signed [ltps_pkg::POS_W-1:0]   pos_x = '0;
    logic signed [ltps_pkg::POS_W-1:0]   pos_z = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [ltps_pkg::KIND_W-1:0]         move_kind;
    logic signed [ltps_pkg::COORD_W-1:0] move_target;
    logic [ltps_pkg::FEED_W-1:0]         move_feed;
    logic [ltps_pkg::SPIN_W-1:0]         spindle_cmd;
    logic [ltps_pkg::RPM_W-1:0]          speed_request;
    logic                                cycle_busy;

    lathe_turning_pass_sequencer_unit DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .event_kind      (event_kind),
        .executor_ready  (executor_ready),
        .spindle_running (spindle_running),
        .pos_x           (pos_x),
        .pos_z           (pos_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .move_kind       (move_kind),
        .move_target     (move_target),
        .move_feed       (move_feed),
        .spindle_cmd     (spindle_cmd),
        .speed_request   (speed_request),
        .cycle_busy      (cycle_busy)
    );

    always #5 clk = ~clk;

    move_cmd_t cmd_expect_q[$];
    int        fail_count = 0;

    // sender and receiver pacing
    bit tx_steady = 1'b0;
    int tx_burst_left = 0;
    int rx_ready_pct = 100;
    int rx_hold_left = 0;

    // register copies
    longint dia_delta, rough_step, finish_allow, cut_len, retract_len;
    longint rough_rate, finish_rate, rpm_req;

    // cycle state
    logic [ltps_pkg::PHASE_W-1:0] cyc_phase;
    bit                           dir_neg;
    longint                       tgt_x, org_x, org_z, depth_done, pass_no, cur_feed;

    function automatic void reset_model();
        dia_delta    = longint'($signed(ltps_pkg::RST_DELTA_DIAMETER));
        rough_step   = longint'(ltps_pkg::RST_ROUGH_DEPTH);
        finish_allow = longint'(ltps_pkg::RST_FINISH_DEPTH);
        cut_len      = longint'($signed(ltps_pkg::RST_CUT_LENGTH));
        retract_len  = longint'(ltps_pkg::RST_RETRACT_DIST);
        rough_rate   = longint'(ltps_pkg::RST_ROUGH_FEED);
        finish_rate  = longint'(ltps_pkg::RST_FINISH_FEED);
        rpm_req      = longint'(ltps_pkg::RST_SPINDLE_RPM);
        cyc_phase    = ltps_pkg::PH_IDLE;
        dir_neg      = 1'b0;
        tgt_x        = 0;
        org_x        = 0;
        org_z        = 0;
        depth_done   = 0;
        pass_no      = 0;
        cur_feed     = 0;
    endfunction

    function automatic void apply_reg(input logic [ltps_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [ltps_pkg::CFG_DAT_W-1:0] data);
        case (idx)
            ltps_pkg::CFG_DELTA_DIAMETER:
                dia_delta    = longint'($signed(data));
            ltps_pkg::CFG_ROUGH_DEPTH:
                rough_step   = longint'(data[ltps_pkg::DEPTH_W-1:0]);
            ltps_pkg::CFG_FINISH_DEPTH:
                finish_allow = longint'(data[ltps_pkg::DEPTH_W-1:0]);
            ltps_pkg::CFG_CUT_LENGTH:
                cut_len      = longint'($signed(data));
            ltps_pkg::CFG_RETRACT_DIST:
                retract_len  = longint'(data[ltps_pkg::DEPTH_W-1:0]);
            ltps_pkg::CFG_ROUGH_FEED:
                rough_rate   = longint'(data[ltps_pkg::FEED_W-1:0]);
            ltps_pkg::CFG_FINISH_FEED:
                finish_rate  = longint'(data[ltps_pkg::FEED_W-1:0]);
            default:
                rpm_req      = longint'(data[ltps_pkg::RPM_W-1:0]);
        endcase
    endfunction

    // advance the cycle by one event and return the command it produces
    function automatic move_cmd_t next_move(input turn_event_t e);
        move_cmd_t c;
        longint    full, diff, off, prod, tgt;
        c   = '0;
        tgt = 0;
        if (e.kind == ltps_pkg::EV_ERROR) begin
            cyc_phase = ltps_pkg::PH_IDLE;
        end
        else if (cyc_phase == ltps_pkg::PH_IDLE) begin
            if (e.kind == ltps_pkg::EV_START && e.exec_rdy) begin
                dir_neg    = dia_delta < 0;
                org_x      = longint'($signed(e.pos_x));
                org_z      = longint'($signed(e.pos_z));
                tgt_x      = org_x;
                depth_done = 0;
                pass_no    = 1;
                cur_feed   = rough_rate;
                cyc_phase  = ltps_pkg::PH_PLAN;
                c.move_kind     = ltps_pkg::MV_SYNC;
                c.speed_request = rpm_req[ltps_pkg::RPM_W-1:0];
                if (!e.spin_run)
                    c.spindle_cmd = ltps_pkg::SP_START;
            end
        end
        else if (e.kind == ltps_pkg::EV_DONE) begin
            case (cyc_phase)
                ltps_pkg::PH_PLAN:
                begin
                    full = dia_delta < 0 ? -dia_delta : dia_delta;
                    diff = full - depth_done;
                    if (diff == 0) begin
                        cyc_phase = ltps_pkg::PH_STOP;
                    end
                    else begin
                        if (diff >= rough_step + finish_allow) begin
                            prod       = pass_no * rough_step;
                            depth_done = prod > 64'h1FFFFF ? 64'h1FFFFF : prod;
                            pass_no    = (pass_no + 1) & 64'hFFFF;
                        end
                        else if (diff <= finish_allow + 1) begin
                            depth_done = full;
                            cur_feed   = finish_rate;
                        end
                        else begin
                            depth_done = full - finish_allow;
                        end
                        // half the diameter step, rounded away from the start
                        off       = (depth_done + 1) >>> 1;
                        tgt_x     = dir_neg ? org_x - off : org_x + off;
                        cyc_phase = ltps_pkg::PH_FEED;
                    end
                    c.move_kind = ltps_pkg::MV_RAPID_X;
                    tgt         = tgt_x;
                end
                ltps_pkg::PH_FEED:
                begin
                    c.move_kind = ltps_pkg::MV_FEED_Z;
                    tgt         = org_z + cut_len;
                    c.move_feed = cur_feed[ltps_pkg::FEED_W-1:0];
                    cyc_phase   = ltps_pkg::PH_RETRACT;
                end
                ltps_pkg::PH_RETRACT:
                begin
                    c.move_kind = ltps_pkg::MV_RAPID_X;
                    tgt         = dir_neg ? tgt_x + retract_len : tgt_x - retract_len;
                    cyc_phase   = ltps_pkg::PH_RETURN;
                end
                ltps_pkg::PH_RETURN:
                begin
                    c.move_kind = ltps_pkg::MV_RAPID_Z;
                    tgt         = org_z;
                    cyc_phase   = ltps_pkg::PH_PLAN;
                end
                default:
                begin
                    cyc_phase = ltps_pkg::PH_IDLE;
                    if (e.spin_run)
                        c.spindle_cmd = ltps_pkg::SP_STOP;
                end
            endcase
        end
        c.move_target = tgt[ltps_pkg::COORD_W-1:0];
        c.cycle_busy  = cyc_phase != ltps_pkg::PH_IDLE;
        return c;
    endfunction

    function automatic logic [ltps_pkg::POS_W-1:0] rand_pos();
        int v;
        case ($urandom_range(0, 9))
            0:       v = 2000000;
            1:       v = -2000000;
            default: v = int'($urandom_range(0, 4000000)) - 2000000;
        endcase
        return v[ltps_pkg::POS_W-1:0];
    endfunction

    function automatic turn_event_t make_event(input logic [ltps_pkg::EVENT_W-1:0] kind,
                                               input logic rdy, input logic run);
        turn_event_t e;
        e.kind     = kind;
        e.exec_rdy = rdy;
        e.spin_run = run;
        e.pos_x    = rand_pos();
        e.pos_z    = rand_pos();
        return e;
    endfunction

    function automatic cut_setup_t random_setup();
        cut_setup_t s;
        int         full;
        full      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000000)
                                                : $urandom_range(0, 5000);
        s.delta   = $urandom_range(0, 1) ? full : -full;
        s.rough   = full / int'($urandom_range(1, 8)) + int'($urandom_range(0, 3));
        if (s.rough > 100000)
            s.rough = 100000;
        if (s.rough < 1)
            s.rough = 1;
        s.finish  = $urandom_range(0, 1) ? $urandom_range(0, 100000)
                                         : $urandom_range(0, s.rough);
        s.length  = int'($urandom_range(0, 2000000)) - 1000000;
        s.retract = $urandom_range(0, 100000);
        s.rfeed   = $urandom_range(1, 10000);
        s.ffeed   = $urandom_range(1, 10000);
        s.rpm     = $urandom_range(0, 65535);
        return s;
    endfunction

    // valid stays high across back-to-back transfers; gaps drop it
    task automatic send_event(input turn_event_t e);
        int gap;
        if (!tx_steady && tx_burst_left == 0) begin
            gap           = $urandom_range(0, 5);
            tx_burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        in_valid        <= 1'b1;
        event_kind      <= e.kind;
        executor_ready  <= e.exec_rdy;
        spindle_running <= e.spin_run;
        pos_x           <= e.pos_x;
        pos_z           <= e.pos_z;
        do @(posedge clk); while (in_ready !== 1'b1);
        cmd_expect_q.push_back(next_move(e));
    endtask

    task automatic send_kind(input logic [ltps_pkg::EVENT_W-1:0] kind, input logic rdy,
                             input logic run);
        send_event(make_event(kind, rdy, run));
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (cmd_expect_q.size() != 0);
    endtask

    task automatic write_reg(input logic [ltps_pkg::CFG_IDX_W-1:0] idx, input int value);
        logic [ltps_pkg::CFG_DAT_W-1:0] word;
        word = value[ltps_pkg::CFG_DAT_W-1:0];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_reg(idx, word);
    endtask

    // drain, let the pipeline settle, then rewrite every register
    task automatic settle_and_load(input cut_setup_t s);
        wait_all_results();
        repeat (4) @(posedge clk);
        write_reg(ltps_pkg::CFG_DELTA_DIAMETER, s.delta);
        write_reg(ltps_pkg::CFG_ROUGH_DEPTH,    s.rough);
        write_reg(ltps_pkg::CFG_FINISH_DEPTH,   s.finish);
        write_reg(ltps_pkg::CFG_CUT_LENGTH,     s.length);
        write_reg(ltps_pkg::CFG_RETRACT_DIST,   s.retract);
        write_reg(ltps_pkg::CFG_ROUGH_FEED,     s.rfeed);
        write_reg(ltps_pkg::CFG_FINISH_FEED,    s.ffeed);
        write_reg(ltps_pkg::CFG_SPINDLE_RPM,    s.rpm);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_to_idle(input logic run);
        while (cyc_phase != ltps_pkg::PH_IDLE)
            send_kind(ltps_pkg::EV_DONE, 1'($urandom_range(0, 1)), run);
    endtask

    // ignored events, start handling and a partial cycle on reset registers
    task automatic test_reset_defaults();
        turn_event_t e;
        send_kind(ltps_pkg::EV_DONE, 1'b1, 1'b1);
        send_kind(EV_UNUSED, 1'b1, 1'b0);
        send_kind(ltps_pkg::EV_ERROR, 1'b1, 1'b1);
        send_kind(ltps_pkg::EV_START, 1'b0, 1'b0);
        e       = make_event(ltps_pkg::EV_START, 1'b1, 1'b0);
        e.pos_x = 22'sd2000000;
        e.pos_z = 22'sd2000000;
        send_event(e);
        send_kind(ltps_pkg::EV_START, 1'b1, 1'b1);
        send_kind(EV_UNUSED, 1'b1, 1'b1);
        repeat (5)
            send_kind(ltps_pkg::EV_DONE, 1'b0, 1'b1);
        send_kind(ltps_pkg::EV_ERROR, 1'b0, 1'b0);
        wait_all_results();
    endtask

    // rough, semi-finish and finish passes through to the spindle stop
    task automatic test_full_cycle();
        cut_setup_t  s;
        turn_event_t e;
        s = '{300, 200, 50, -5000, 30, 150, 40, 1200};
        settle_and_load(s);
        e       = make_event(ltps_pkg::EV_START, 1'b1, 1'b1);
        e.pos_x = -22'sd2000000;
        e.pos_z = -22'sd2000000;
        send_event(e);
        run_to_idle(1'b1);
        wait_all_results();
    endtask

    task automatic test_edge_configs();
        cut_setup_t s;
        // zero depth: plan goes straight to the stop
        s = '{0, 200, 100, 500, 10, 100, 50, 300};
        settle_and_load(s);
        send_kind(ltps_pkg::EV_START, 1'b1, 1'b1);
        run_to_idle(1'b0);
        // zero rough depth repeats the same pass until an error
        s = '{-2000, 0, 0, -700, 25, 90, 30, 2500};
        settle_and_load(s);
        send_kind(ltps_pkg::EV_START, 1'b1, 1'b0);
        repeat (9)
            send_kind(ltps_pkg::EV_DONE, 1'b1, 1'b1);
        send_kind(ltps_pkg::EV_ERROR, 1'b1, 1'b1);
        // no finish allowance: finish pass taken with one micrometre left
        s = '{-201, 100, 0, 900, 5, 70, 20, 800};
        settle_and_load(s);
        send_kind(ltps_pkg::EV_START, 1'b1, 1'b0);
        run_to_idle(1'b1);
        wait_all_results();
    endtask

    // hold the output long enough to fill the unit and stall its input
    task automatic test_backpressure();
        tx_steady    = 1'b1;
        rx_hold_left = 150;
        send_kind(ltps_pkg::EV_START, 1'b1, 1'b0);
        repeat (40)
            send_kind(ltps_pkg::EV_DONE, 1'b1, 1'b1);
        send_kind(ltps_pkg::EV_ERROR, 1'b1, 1'b1);
        tx_steady = 1'b0;
        wait_all_results();
    endtask

    task automatic random_event();
        turn_event_t e;
        int          r;
        e = make_event(ltps_pkg::EV_DONE, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        r = $urandom_range(0, 99);
        if (cyc_phase == ltps_pkg::PH_IDLE) begin
            if (r < 80) begin
                e.kind     = ltps_pkg::EV_START;
                e.exec_rdy = 1'b1;
            end
            else if (r < 86)
                e.kind = ltps_pkg::EV_START;
            else if (r < 92)
                e.kind = ltps_pkg::EV_DONE;
            else if (r < 96)
                e.kind = ltps_pkg::EV_ERROR;
            else
                e.kind = EV_UNUSED;
        end
        else begin
            if (r < 92)
                e.kind = ltps_pkg::EV_DONE;
            else if (r < 95)
                e.kind = ltps_pkg::EV_ERROR;
            else if (r < 98)
                e.kind = ltps_pkg::EV_START;
            else
                e.kind = EV_UNUSED;
        end
        send_event(e);
    endtask

    task automatic test_random_cycles();
        cut_setup_t s;
        int         counted;
        int         n;
        bit         busy;
        counted = 0;
        for (int round = 0; counted < 1600; round++) begin
            if (round == 0)
                s = '{1000000, 100000, 100000, 1000000, 100000, 10000, 10000, 65535};
            else if (round == 1)
                s = '{-1000000, 100000, 0, -1000000, 0, 1, 1, 0};
            else
                s = random_setup();
            settle_and_load(s);
            case ($urandom_range(0, 3))
                0:       rx_ready_pct = 100;
                1:       rx_ready_pct = 85;
                2:       rx_ready_pct = 50;
                default: rx_ready_pct = 20;
            endcase
            tx_steady = $urandom_range(0, 3) == 0;
            n = 0;
            while (n < 150) begin
                busy = cyc_phase != ltps_pkg::PH_IDLE;
                random_event();
                // events ignored while idle do not count toward the total
                if (cmd_expect_q.size() != 0 &&
                    (cmd_expect_q[$].move_kind != ltps_pkg::MV_NONE || busy)) begin
                    n++;
                    counted++;
                end
            end
            send_kind(ltps_pkg::EV_ERROR, 1'b1, 1'b0);
        end
        tx_steady    = 1'b0;
        rx_ready_pct = 100;
        wait_all_results();
    endtask

    always @(posedge clk) begin
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else begin
            out_ready <= $urandom_range(0, 99) < rx_ready_pct;
        end
    end

    always @(posedge clk) begin
        move_cmd_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
            if (cmd_expect_q.size() == 0) begin
                $error("unexpected command transfer: move_kind %0d", move_kind);
                fail_count++;
            end
            else begin
                want = cmd_expect_q.pop_front();
                if (move_kind !== want.move_kind) begin
                    $error("move_kind: expected %0d, got %0d", want.move_kind, move_kind);
                    fail_count++;
                end
                if (move_target !== want.move_target) begin
                    $error("move_target: expected %0d, got %0d",
                           $signed(want.move_target), move_target);
                    fail_count++;
                end
                if (move_feed !== want.move_feed) begin
                    $error("move_feed: expected %0d, got %0d", want.move_feed, move_feed);
                    fail_count++;
                end
                if (spindle_cmd !== want.spindle_cmd) begin
                    $error("spindle_cmd: expected %0d, got %0d",
                           want.spindle_cmd, spindle_cmd);
                    fail_count++;
                end
                if (speed_request !== want.speed_request) begin
                    $error("speed_request: expected %0d, got %0d",
                           want.speed_request, speed_request);
                    fail_count++;
                end
                if (cycle_busy !== want.cycle_busy) begin
                    $error("cycle_busy: expected %0d, got %0d", want.cycle_busy, cycle_busy);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_full_cycle();
        test_edge_configs();
        test_backpressure();
        test_random_cycles();
        repeat (10) @(posedge clk);
        if (cmd_expect_q.size() != 0) begin
            $error("%0d expected commands never arrived", cmd_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ltps_pkg.sv
sv/lathe_turning_pass_sequencer_unit.sv
tb/tb_lathe_turning_pass_sequencer_unit.sv
